[rtl/core/mkd_pkg.sv]
`default_nettype none

package mkd_pkg;

    // Field widths of the channels and the configuration port.
    localparam int CNT_W   = 11;
    localparam int EV_W    = 3;
    localparam int LET_W   = 5;
    localparam int SCNT_W  = 3;
    localparam int CIDX_W  = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_DASH  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_ERROR = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_GAP   = 2'd2;

    // Register values after reset.
    localparam logic [CNT_W-1:0] DASH_RESET  = 11'd250;
    localparam logic [CNT_W-1:0] ERROR_RESET = 11'd700;
    localparam logic [CNT_W-1:0] GAP_RESET   = 11'd400;

    localparam int NUM_LETTERS = 26;

    // Event codes carried by a result item.
    typedef enum logic [EV_W-1:0] {
        EV_DOT     = 3'd0,
        EV_DASH    = 3'd1,
        EV_LONG    = 3'd2,
        EV_TOOMANY = 3'd3,
        EV_LETTER  = 3'd4,
        EV_INVALID = 3'd5
    } t_event;

    // Decoder phase, one-hot.
    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PRESS = 3'b010,
        PH_GAP   = 3'b100
    } t_phase;

    // International Morse A-Z: symbol count and dash pattern (bit i = symbol i).
    localparam logic [2:0] CODE_LEN [NUM_LETTERS] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };
    localparam logic [3:0] CODE_BITS [NUM_LETTERS] = '{
        4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2, 4'd3,
        4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
    };

    typedef struct packed {
        logic             found;
        logic [LET_W-1:0] letter;
    } t_match;

    // Looks the symbol store up in the letter table; the first hit wins.
    function automatic t_match match_letter(input logic [2:0] count,
                                            input logic [7:0] bits);
        t_match res;
        res = '0;
        for (int i = NUM_LETTERS - 1; i >= 0; i--) begin
            if (CODE_LEN[i] == count && 8'(CODE_BITS[i]) == bits) begin
                res.found  = 1'b1;
                res.letter = LET_W'(i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/core/mkd_in_if.sv]
`default_nettype none

interface mkd_in_if;
    logic valid;
    logic ready;
    logic key_level;

    modport source (output valid, output key_level, input ready);
    modport sink (input valid, input key_level, output ready);
endinterface

`default_nettype wire

[rtl/core/mkd_out_if.sv]
`default_nettype none

interface mkd_out_if;
    logic                       valid;
    logic                       ready;
    logic [mkd_pkg::EV_W-1:0]   event_code;
    logic [mkd_pkg::LET_W-1:0]  letter_index;
    logic [mkd_pkg::SCNT_W-1:0] symbol_count;

    modport source (output valid, output event_code, output letter_index,
                    output symbol_count, input ready);
    modport sink (input valid, input event_code, input letter_index,
                  input symbol_count, output ready);
endinterface

`default_nettype wire

[rtl/core/morse_key_decoder.sv]
// Morse key decoder.
// i_in carries one item per millisecond tick with the key level; o_out carries
// an item for each judged press (dot, dash, long press, too many symbols) and
// for each finished character (letter index or invalid code). Most ticks give
// no result item.
// An accepted item waits in the input register; the decode logic then writes
// its result, if any, to the result register, which drives o_out. One item
// per cycle is taken as long as the result register is free or being
// emptied in the same cycle.
// When the receiver stalls, the pending result holds in the result register,
// the input register keeps the next item, and i_in.ready drops once both are
// full; nothing is lost or repeated.
// The three thresholds are written through i_cfg_we / i_cfg_index / i_cfg_data
// by the user only while the block is idle (unenforced); other indexes are ignored.
// A synchronous reset (i_rst_n low) empties both registers, clears the symbol
// store and counters, and loads the thresholds 250, 700 and 400 ticks.

`default_nettype none

module morse_key_decoder #(
    parameter int MAX_SYMBOLS = 4
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    mkd_in_if.sink                       i_in,
    mkd_out_if.source                    o_out,
    input  wire                          i_cfg_we,
    input  wire [mkd_pkg::CIDX_W-1:0]    i_cfg_index,
    input  wire [mkd_pkg::CNT_W-1:0]     i_cfg_data
);

    localparam int CW = mkd_pkg::CNT_W;

    // Configuration registers.
    logic [CW-1:0] r_dash_thr;
    logic [CW-1:0] r_err_thr;
    logic [CW-1:0] r_gap_thr;

    // Input register.
    logic r_s1_valid;
    logic r_s1_key;

    // Decoder state.
    mkd_pkg::t_phase          r_phase, n_phase;
    logic [CW-1:0]            r_press, n_press;
    logic [CW-1:0]            r_gap, n_gap;
    logic [MAX_SYMBOLS-1:0]   r_dash, n_dash;
    logic [2:0]               r_held, n_held;

    // Result register.
    logic                          r_out_valid;
    mkd_pkg::t_event               r_ev, n_ev;
    logic [mkd_pkg::LET_W-1:0]     r_letter, n_letter;
    logic [mkd_pkg::SCNT_W-1:0]    r_count, n_count;
    logic                          n_res;

    logic           s_adv;
    logic           s_fire;
    mkd_pkg::t_match s_match;

    assign s_adv  = !r_out_valid || o_out.ready;
    assign s_fire = r_s1_valid && s_adv;

    assign i_in.ready = !r_s1_valid || s_adv;

    assign o_out.valid        = r_out_valid;
    assign o_out.event_code   = r_ev;
    assign o_out.letter_index = r_letter;
    assign o_out.symbol_count = r_count;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dash_thr <= mkd_pkg::DASH_RESET;
            r_err_thr  <= mkd_pkg::ERROR_RESET;
            r_gap_thr  <= mkd_pkg::GAP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mkd_pkg::CFG_DASH:  r_dash_thr <= i_cfg_data;
                mkd_pkg::CFG_ERROR: r_err_thr  <= i_cfg_data;
                mkd_pkg::CFG_GAP:   r_gap_thr  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: takes a new item whenever it is empty or the result register can advance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_s1_key <= i_in.key_level;
        end
    end

    assign s_match = mkd_pkg::match_letter(r_held, 8'(r_dash));

    // Decode of one tick against the current state.
    always_comb begin
        n_phase  = r_phase;
        n_press  = r_press;
        n_gap    = r_gap;
        n_dash   = r_dash;
        n_held   = r_held;
        n_res    = 1'b0;
        n_ev     = mkd_pkg::EV_DOT;
        n_letter = '0;
        case (r_phase)
            mkd_pkg::PH_PRESS: begin
                if (r_s1_key) begin
                    if (r_press != mkd_pkg::CNT_MAX) begin
                        n_press = r_press + CW'(1);
                    end
                end else if (r_press > r_err_thr) begin
                    n_res   = 1'b1;
                    n_ev    = mkd_pkg::EV_LONG;
                    n_dash  = '0;
                    n_held  = '0;
                    n_phase = mkd_pkg::PH_IDLE;
                end else if (r_held >= 3'(MAX_SYMBOLS)) begin
                    n_res   = 1'b1;
                    n_ev    = mkd_pkg::EV_TOOMANY;
                    n_dash  = '0;
                    n_held  = '0;
                    n_phase = mkd_pkg::PH_IDLE;
                end else begin
                    // Store the symbol; bit position is the current count.
                    n_res = 1'b1;
                    if (r_press >= r_dash_thr) begin
                        n_ev = mkd_pkg::EV_DASH;
                        for (int j = 0; j < MAX_SYMBOLS; j++) begin
                            if (r_held == 3'(j)) begin
                                n_dash[j] = 1'b1;
                            end
                        end
                    end
                    n_held  = r_held + 3'd1;
                    n_phase = mkd_pkg::PH_GAP;
                    n_gap   = '0;
                end
            end
            mkd_pkg::PH_GAP: begin
                if (r_s1_key) begin
                    n_phase = mkd_pkg::PH_PRESS;
                    n_press = CW'(1);
                end else if (r_gap >= r_gap_thr) begin
                    // Character ends: look the store up and clear it.
                    n_res   = 1'b1;
                    n_dash  = '0;
                    n_held  = '0;
                    n_phase = mkd_pkg::PH_IDLE;
                    if (s_match.found) begin
                        n_ev     = mkd_pkg::EV_LETTER;
                        n_letter = s_match.letter;
                    end else begin
                        n_ev = mkd_pkg::EV_INVALID;
                    end
                end else begin
                    n_gap = r_gap + CW'(1);
                end
            end
            default: begin
                n_phase = mkd_pkg::PH_IDLE;
                if (r_s1_key) begin
                    n_phase = mkd_pkg::PH_PRESS;
                    n_press = CW'(1);
                end
            end
        endcase
        n_count = n_held;
    end

    // Decoder state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mkd_pkg::PH_IDLE;
            r_press <= '0;
            r_gap   <= '0;
            r_dash  <= '0;
            r_held  <= '0;
        end else if (s_fire) begin
            r_phase <= n_phase;
            r_press <= n_press;
            r_gap   <= n_gap;
            r_dash  <= n_dash;
            r_held  <= n_held;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_adv) begin
            r_out_valid <= s_fire && n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire && n_res) begin
            r_ev     <= n_ev;
            r_letter <= n_letter;
            r_count  <= n_count;
        end
    end

    // A stalled result freezes the decoder state.
    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> ($stable(r_phase) && $stable(r_held)
                                          && $stable(r_dash)))
        else $error("decoder state moved while the result was stalled");

    // The symbol store never holds more than its capacity.
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= 3'(MAX_SYMBOLS))
        else $error("symbol count above capacity");

    // Events that clear the store report an empty store.
    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_ev == mkd_pkg::EV_LONG || r_ev == mkd_pkg::EV_TOOMANY
                         || r_ev == mkd_pkg::EV_LETTER || r_ev == mkd_pkg::EV_INVALID))
        |-> (r_count == '0))
        else $error("clearing event with nonzero symbol count");

    // A letter index appears only with a letter event.
    a_letter_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ev != mkd_pkg::EV_LETTER) |-> (r_letter == '0))
        else $error("letter index set on a non-letter event");

    // A running press has counted at least its first tick.
    a_press_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == mkd_pkg::PH_PRESS) |-> (r_press != '0))
        else $error("press phase with zero press count");

endmodule

`default_nettype wire
